### rtl/core/u2u_pkg.sv
// u2u_pkg: shared types, constants and the utf-8 unit encoder
// used by u2u_step and ucs2_to_utf8_stream; no dependencies
`default_nettype none

package u2u_pkg;

    localparam logic [1:0] PH_MARK0 = 2'd0;
    localparam logic [1:0] PH_MARK1 = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    localparam logic [7:0] BOM_FF   = 8'hFF;
    localparam logic [7:0] BOM_FE   = 8'hFE;
    localparam logic [7:0] MARK_0   = 8'hEF;
    localparam logic [7:0] MARK_1   = 8'hBB;
    localparam logic [7:0] MARK_2   = 8'hBF;
    localparam logic [7:0] LEAD_2   = 8'hC0;
    localparam logic [7:0] LEAD_3   = 8'hE0;
    localparam logic [7:0] CONT     = 8'h80;
    localparam logic [15:0] LIM_1B  = 16'd128;
    localparam logic [15:0] LIM_2B  = 16'd2048;

    localparam int MAX_RES = 6;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] first_byte;
        logic [7:0] pending_byte;
        logic       pending_valid;
        logic       big_endian;
    } u2u_state_t;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
    } u2u_unit_t;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [2:0]              cnt;
        logic                    err;
        logic                    status_only;
    } u2u_job_t;

    function automatic u2u_unit_t encode_unit(input logic [15:0] u);
        u2u_unit_t r;
        r = '0;
        if (u < LIM_1B)
        begin
            r.bytes[0] = u[7:0];
            r.cnt      = 2'd1;
        end
        else if (u < LIM_2B)
        begin
            r.bytes[0] = LEAD_2 | {3'b000, u[10:6]};
            r.bytes[1] = CONT | {2'b00, u[5:0]};
            r.cnt      = 2'd2;
        end
        else
        begin
            r.bytes[0] = LEAD_3 | {4'b0000, u[15:12]};
            r.bytes[1] = CONT | {2'b00, u[11:6]};
            r.bytes[2] = CONT | {2'b00, u[5:0]};
            r.cnt      = 2'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/u2u_in_if.sv
// u2u_in_if: request channel carrying one ucs-2 byte per transfer
// no dependencies
`default_nettype none

interface u2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

### rtl/core/u2u_out_if.sv
// u2u_out_if: result channel carrying one utf-8 byte or status per transfer
// no dependencies
`default_nettype none

interface u2u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       odd_length_error;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid,
                    output odd_length_error, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input odd_length_error, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/u2u_step.sv
// u2u_step: decodes one input byte against the stream state into the next
// state and the list of result bytes; depends on u2u_pkg
`default_nettype none

module u2u_step (
    input  wire u2u_pkg::u2u_state_t st,
    input  wire logic [7:0]          data_byte,
    input  wire logic                end_of_stream,
    input  wire logic                default_big_endian,
    output u2u_pkg::u2u_state_t      st_next,
    output u2u_pkg::u2u_job_t        job
);
    import u2u_pkg::*;

    logic       emit_mark;
    logic       emit_unit;
    logic       err;
    logic [7:0] unit_a;
    logic       unit_be;
    logic [15:0] unit_word;
    u2u_unit_t  unit;

    always_comb
    begin
        st_next   = st;
        emit_mark = 1'b0;
        emit_unit = 1'b0;
        err       = 1'b0;
        unit_a    = st.pending_byte;
        unit_be   = st.big_endian;
        unique case (st.phase)
            PH_MARK0:
            begin
                st_next.first_byte    = data_byte;
                st_next.pending_valid = 1'b0;
                if (end_of_stream)
                begin
                    emit_mark = 1'b1;
                    err       = 1'b1;
                end
                else
                begin
                    st_next.phase = PH_MARK1;
                end
            end
            PH_MARK1:
            begin
                st_next.phase = PH_DATA;
                emit_mark     = 1'b1;
                if (st.first_byte == BOM_FF && data_byte == BOM_FE)
                begin
                    st_next.big_endian = 1'b0;
                end
                else if (st.first_byte == BOM_FE && data_byte == BOM_FF)
                begin
                    st_next.big_endian = 1'b1;
                end
                else if (st.first_byte == BOM_FE || st.first_byte == BOM_FF)
                begin
                    st_next.big_endian    = (st.first_byte == BOM_FF);
                    st_next.pending_byte  = data_byte;
                    st_next.pending_valid = 1'b1;
                    err                   = 1'b1;
                end
                else
                begin
                    st_next.big_endian = default_big_endian;
                    emit_unit          = 1'b1;
                    unit_a             = st.first_byte;
                    unit_be            = default_big_endian;
                end
            end
            default:
            begin
                if (!st.pending_valid)
                begin
                    st_next.pending_byte  = data_byte;
                    st_next.pending_valid = 1'b1;
                end
                else
                begin
                    emit_unit             = 1'b1;
                    st_next.pending_valid = 1'b0;
                end
            end
        endcase
        if (end_of_stream)
        begin
            if (st_next.pending_valid)
            begin
                err = 1'b1;
            end
            st_next.pending_valid = 1'b0;
            st_next.phase         = PH_MARK0;
        end
    end

    assign unit_word = unit_be ? {unit_a, data_byte} : {data_byte, unit_a};
    assign unit      = encode_unit(unit_word);

    always_comb
    begin
        job             = '0;
        job.err         = err;
        if (emit_mark)
        begin
            job.bytes[0] = MARK_0;
            job.bytes[1] = MARK_1;
            job.bytes[2] = MARK_2;
            job.bytes[3] = unit.bytes[0];
            job.bytes[4] = unit.bytes[1];
            job.bytes[5] = unit.bytes[2];
            job.cnt      = emit_unit ? ({1'b0, unit.cnt} + 3'd3) : 3'd3;
        end
        else if (emit_unit)
        begin
            job.bytes[0] = unit.bytes[0];
            job.bytes[1] = unit.bytes[1];
            job.bytes[2] = unit.bytes[2];
            job.cnt      = {1'b0, unit.cnt};
        end
        else if (err)
        begin
            job.cnt         = 3'd1;
            job.status_only = 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ucs2_to_utf8_stream.sv
// ucs2_to_utf8_stream: ucs-2 byte stream to utf-8 byte stream converter
// depends on u2u_pkg, u2u_in_if, u2u_out_if and u2u_step
//
// usage
//   ucs2 channel: one byte per request, end_of_stream on the final byte.
//   the first two bytes of a stream are checked for a byte order mark;
//   once the order is settled the utf-8 mark EF BB BF is sent, then each
//   16-bit unit as 1 to 3 bytes. utf8 channel: one byte per request, last
//   marks the final result of an input byte; a status-only result has
//   byte_valid low. cfg_wr_en/cfg_wr_data set the default byte order, to be
//   written by the user only while idle, which the block does not enforce; it applies from the next stream.
// timing
//   a request is taken into an input register, then decoded into a result
//   buffer of up to six bytes once that buffer is empty or its last byte
//   leaves; the buffer drives the output directly. the buffer drains one
//   byte per cycle while the receiver is ready, and the next request is
//   decoded as the last byte leaves; a byte that yields no result leaves
//   the buffer empty.
// reset and stall
//   reset empties both registers and returns to awaiting a mark. while the
//   receiver stalls the result holds and one more request is still taken.
`default_nettype none

module ucs2_to_utf8_stream (
    input  wire logic   clk,
    input  wire logic   rst_n,
    u2u_in_if.sink      ucs2,
    u2u_out_if.source   utf8,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data
);
    import u2u_pkg::*;

    logic        default_be_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eos_reg;

    u2u_state_t  st_reg;
    u2u_state_t  st_next;
    u2u_job_t    job_next;

    logic [MAX_RES-1:0][7:0] job_bytes_reg;
    logic [2:0]  job_cnt_reg;
    logic        job_err_reg;
    logic        job_stat_reg;

    logic        out_take;
    logic        last_take;
    logic        s1_move;
    logic        in_take;

    assign out_take  = utf8.valid && utf8.ready;
    assign last_take = out_take && (job_cnt_reg == 3'd1);
    assign s1_move   = s1_valid_reg && ((job_cnt_reg == 3'd0) || last_take);
    assign ucs2.ready = !s1_valid_reg || s1_move;
    assign in_take   = ucs2.valid && ucs2.ready;

    assign utf8.valid            = (job_cnt_reg != 3'd0);
    assign utf8.out_byte         = job_bytes_reg[0];
    assign utf8.byte_valid       = !job_stat_reg;
    assign utf8.last             = (job_cnt_reg == 3'd1);
    assign utf8.odd_length_error = job_err_reg && (job_cnt_reg == 3'd1);

    u2u_step step_i (
        .st                 (st_reg),
        .data_byte          (s1_byte_reg),
        .end_of_stream      (s1_eos_reg),
        .default_big_endian (default_be_reg),
        .st_next            (st_next),
        .job                (job_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_be_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            default_be_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            st_reg.phase         <= PH_MARK0;
            st_reg.first_byte    <= 8'h00;
            st_reg.pending_byte  <= 8'h00;
            st_reg.pending_valid <= 1'b0;
            st_reg.big_endian    <= 1'b0;
            job_cnt_reg          <= 3'd0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                st_reg      <= st_next;
                job_cnt_reg <= job_next.cnt;
            end
            else if (out_take)
            begin
                job_cnt_reg <= job_cnt_reg - 3'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= ucs2.data_byte;
            s1_eos_reg  <= ucs2.end_of_stream;
        end
        if (s1_move)
        begin
            job_bytes_reg       <= job_next.bytes;
            job_err_reg         <= job_next.err;
            job_stat_reg        <= job_next.status_only;
        end
        else if (out_take)
        begin
            job_bytes_reg <= {8'h00, job_bytes_reg[MAX_RES-1:1]};
        end
    end

endmodule

`default_nettype wire

### rtl/core/u2u_checker.sv
// u2u_checker: port-level assertions for ucs2_to_utf8_stream
// bound to the top level below; depends only on its ports
`default_nettype none

module u2u_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       odd_length_error,
    input wire logic       last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

    // error flag only on the final result of a request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && odd_length_error |-> last)
        else $error("error flag before last result");

    // status-only result is a flagged final result with zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && odd_length_error && (out_byte == 8'h00))
        else $error("bad status-only result");

    // a non-final data result is followed by another result of the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && byte_valid)
        else $error("result list cut short");

endmodule

bind ucs2_to_utf8_stream u2u_checker chk_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (utf8.valid),
    .out_ready        (utf8.ready),
    .out_byte         (utf8.out_byte),
    .byte_valid       (utf8.byte_valid),
    .odd_length_error (utf8.odd_length_error),
    .last             (utf8.last)
);

`default_nettype wire
